// ===== hw/rtl/dgv_pkg.sv =====
// Package: shared types, constants and helpers for the grid volume block.
package dgv_pkg;

    localparam int GRID_WIDTH  = 640;
    localparam int GRID_HEIGHT = 480;
    localparam int COL_W       = $clog2(GRID_WIDTH);
    localparam int ROW_W       = $clog2(GRID_HEIGHT);

    localparam int COORD_W  = 20;
    localparam int NORM_W   = 16;
    localparam int OFF_W    = 20;
    localparam int MINH_W   = 19;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;
    localparam int EDGE_W   = COORD_W + 1;
    localparam int OPND_W   = 25;
    localparam int PROD_W   = 2 * OPND_W;
    localparam int ACC_W    = 68;
    localparam int FRAC_SH  = 14;
    localparam int H_W      = 37;
    localparam int HS_W     = 39;
    localparam int CROSS_W  = 43;
    localparam int SPLIT    = 24;
    localparam int D_W      = 62;
    localparam int AQ_SH    = 18;
    localparam int AQ_W     = 42;
    localparam int HQ_W     = 24;
    localparam int VOL_W    = 40;
    localparam int CNT_W    = 20;
    localparam int DIV_SH   = 9;
    localparam int DIVX_W   = 42;
    localparam int DIV_BITS = 7;
    localparam int DIV_STEPS = DIVX_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int STEP_W   = 3;

    localparam logic [VOL_W-1:0] VOL_MAX = {VOL_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    // (prod >> 9) at or above 3 * 2^40 gives a volume that always saturates
    localparam logic [ACC_W-DIV_SH-1:0] DIV_LIMIT =
        (ACC_W-DIV_SH)'(3) << VOL_W;

    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_NX     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_NY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_NZ     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT   = 3'd4;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
        logic                      frame_end;
    } vertex_in_t;

    typedef struct packed {
        logic [VOL_W-1:0] volume_mm3;
        logic [CNT_W-1:0] triangle_count;
        logic             overflow;
    } result_t;

    typedef struct packed {
        logic                      ok;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } vertex_t;

    typedef struct packed {
        logic                     clear;
        logic                     add_off;
        logic                     shift;
        logic signed [OPND_W-1:0] a;
        logic signed [OPND_W-1:0] b;
    } mac_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HCUR,
        ST_CHECK,
        ST_HLA,
        ST_HLA_DONE,
        ST_HV0,
        ST_HSUM,
        ST_CROSS,
        ST_DOT,
        ST_AREA,
        ST_PROD,
        ST_DIV,
        ST_ACC,
        ST_FINISH
    } state_t;

    function automatic logic signed [OPND_W-1:0] ext_c(input logic signed [COORD_W-1:0] v);
        return {{(OPND_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    function automatic logic signed [OPND_W-1:0] ext_n(input logic signed [NORM_W-1:0] v);
        return {{(OPND_W-NORM_W){v[NORM_W-1]}}, v};
    endfunction

    function automatic logic signed [OPND_W-1:0] ext_e(input logic signed [EDGE_W-1:0] v);
        return {{(OPND_W-EDGE_W){v[EDGE_W-1]}}, v};
    endfunction

    function automatic logic signed [EDGE_W-1:0] edge_of(
        input logic signed [COORD_W-1:0] hi,
        input logic signed [COORD_W-1:0] lo
    );
        return {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
    endfunction

endpackage

// ===== hw/rtl/dgv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dgv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/dgv_mac.sv =====
// Shared multiply-accumulate unit: one signed 25x25 product per cycle.
module dgv_mac (
    input  logic                             clk,
    input  dgv_pkg::mac_op_t                 op,
    input  logic signed [dgv_pkg::OFF_W-1:0] offset,
    output logic signed [dgv_pkg::ACC_W-1:0] acc
);

    logic signed [dgv_pkg::ACC_W-1:0]  acc_reg;
    logic signed [dgv_pkg::ACC_W-1:0]  acc_next;
    logic signed [dgv_pkg::PROD_W-1:0] prod;
    logic signed [dgv_pkg::ACC_W-1:0]  prod_ext;
    logic signed [dgv_pkg::ACC_W-1:0]  off_term;
    logic signed [dgv_pkg::ACC_W-1:0]  base;

    always_comb
    begin
        prod     = op.a * op.b;
        prod_ext = {{(dgv_pkg::ACC_W-dgv_pkg::PROD_W){prod[dgv_pkg::PROD_W-1]}}, prod};
        if (op.shift)
        begin
            prod_ext = prod_ext <<< dgv_pkg::SPLIT;
        end
        // plane constant, Q16.4 scaled to the Q.18 height format
        off_term = {{(dgv_pkg::ACC_W-dgv_pkg::OFF_W-dgv_pkg::FRAC_SH){offset[dgv_pkg::OFF_W-1]}},
                    offset, {dgv_pkg::FRAC_SH{1'b0}}};
        base     = op.clear ? '0 : acc_reg;
        acc_next = base + (op.add_off ? off_term : '0) + prod_ext;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// ===== hw/rtl/dgv_div3.sv =====
// Divide-by-three unit, seven quotient bits per cycle.
module dgv_div3 (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [dgv_pkg::DIVX_W-1:0]  dividend,
    output logic [dgv_pkg::DIVX_W-1:0]  quotient,
    output logic                        done
);

    logic [dgv_pkg::DIVX_W-1:0]    x_reg, x_next;
    logic [dgv_pkg::DIVX_W-1:0]    q_reg, q_next;
    logic [1:0]                    r_reg, r_next;
    logic [dgv_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [dgv_pkg::DIV_BITS-1:0]  qbits;
    logic [2:0]                    t;
    logic [1:0]                    r;

    always_comb
    begin
        x_next    = x_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        qbits     = '0;
        r         = r_reg;
        for (int i = dgv_pkg::DIV_BITS - 1; i >= 0; i--)
        begin
            t = {r, x_reg[dgv_pkg::DIVX_W-dgv_pkg::DIV_BITS+i]};
            qbits[i] = (t >= 3'd3);
            r = qbits[i] ? 2'(t - 3'd3) : t[1:0];
        end
        if (start)
        begin
            x_next    = dividend;
            q_next    = '0;
            r_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next = x_reg << dgv_pkg::DIV_BITS;
            q_next = {q_reg[dgv_pkg::DIVX_W-dgv_pkg::DIV_BITS-1:0], qbits};
            r_next = r;
            if (cnt_reg == dgv_pkg::DIV_CNT_W'(dgv_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

// ===== hw/rtl/depth_grid_volume_above_plane.sv =====
// Top level: volume above a plane from a raster grid of depth vertices.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+----------------------------------
//   vtx     | in        | vtx_valid/vtx_stall  | coord_x/y/z, frame_end
//   res     | out       | res_valid/res_stall  | volume_mm3, triangle_count, overflow
//   cfg     | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A vertex is finished before the next is taken; a triangle it closes (lower, upper
// or both) adds the cross, dot, product and divide steps, and every product runs
// through the one shared 25x25 multiply-accumulate unit under the sequencer below.
// Reset clears control and frame state; the line store holds stale data that
// is only used from the second row of a frame on. A result waits in an output
// register; a frame end is held back only while a previous result is stalled.
module depth_grid_volume_above_plane (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   vtx_valid,
    output logic                                   vtx_stall,
    input  dgv_pkg::vertex_in_t                    vtx,
    output logic                                   res_valid,
    input  logic                                   res_stall,
    output dgv_pkg::result_t                       res,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [dgv_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [dgv_pkg::CFG_DAT_W-1:0]          cfg_data
);

    // configuration
    logic signed [dgv_pkg::NORM_W-1:0] nx_reg, ny_reg, nz_reg;
    logic signed [dgv_pkg::OFF_W-1:0]  off_reg;
    logic [dgv_pkg::MINH_W-1:0]        minh_reg;

    // sequencer
    dgv_pkg::state_t             state_reg, state_next;
    logic [dgv_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        tri_b_reg, tri_b_next;
    logic                        do_a_reg, do_a_next;
    logic                        do_b_reg, do_b_next;

    // frame state
    logic [dgv_pkg::COL_W-1:0]   col_reg, col_next;
    logic [dgv_pkg::ROW_W-1:0]   row_reg, row_next;
    dgv_pkg::vertex_t            left_reg, left_next;
    dgv_pkg::vertex_t            ul_reg, ul_next;
    logic [dgv_pkg::VOL_W-1:0]   sum_reg, sum_next;
    logic [dgv_pkg::CNT_W-1:0]   tally_reg, tally_next;
    logic                        flag_reg, flag_next;
    logic                        res_valid_reg, res_valid_next;
    dgv_pkg::result_t            res_reg, res_next;

    // item datapath
    dgv_pkg::vertex_t                   cur_reg, cur_next;
    logic                               fe_reg, fe_next;
    dgv_pkg::vertex_t                   above_reg, above_next;
    logic signed [dgv_pkg::H_W-1:0]     hcur_reg, hcur_next;
    logic signed [dgv_pkg::HS_W-1:0]    hla_reg, hla_next;
    logic signed [dgv_pkg::HS_W-1:0]    hs_reg, hs_next;
    logic signed [dgv_pkg::CROSS_W-1:0] cx_reg, cx_next;
    logic signed [dgv_pkg::CROSS_W-1:0] cy_reg, cy_next;
    logic signed [dgv_pkg::CROSS_W-1:0] cz_reg, cz_next;
    logic [dgv_pkg::AQ_W-1:0]           aq_reg, aq_next;
    logic [dgv_pkg::HQ_W-1:0]           hq_reg, hq_next;
    logic                               big_reg, big_next;

    // shared units
    dgv_pkg::mac_op_t                   op;
    logic signed [dgv_pkg::ACC_W-1:0]   acc;
    logic                               div_start;
    logic [dgv_pkg::DIVX_W-1:0]         div_q;
    logic                               div_done;
    logic [$bits(dgv_pkg::vertex_t)-1:0] ram_rdata;
    logic                               ram_we;

    // combinational helpers
    logic                               accepted;
    logic                               hold_out;
    dgv_pkg::vertex_t                   hv, v0, v1, v2;
    logic [1:0]                         k;
    logic signed [dgv_pkg::EDGE_W-1:0]  e0x, e0y, e0z, e1x, e1y, e1z;
    logic signed [dgv_pkg::H_W-1:0]     h_acc;
    logic signed [dgv_pkg::H_W-1:0]     min_term;
    logic signed [dgv_pkg::D_W-1:0]     d_acc;
    logic [dgv_pkg::D_W-1:0]            p_abs;
    logic signed [dgv_pkg::CROSS_W-1:0] csel;
    logic signed [dgv_pkg::NORM_W-1:0]  nsel;
    logic [dgv_pkg::VOL_W:0]            sum_wide;
    logic                               last_step3, last_step6;

    assign accepted  = vtx_valid && !vtx_stall;
    assign vtx_stall = (state_reg != dgv_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign hold_out  = fe_reg && res_valid_reg && res_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg   <= '0;
            ny_reg   <= '0;
            nz_reg   <= 16'shC000;
            off_reg  <= '0;
            minh_reg <= 19'd160;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dgv_pkg::CFG_PLANE_NX:     nx_reg   <= cfg_data[dgv_pkg::NORM_W-1:0];
                dgv_pkg::CFG_PLANE_NY:     ny_reg   <= cfg_data[dgv_pkg::NORM_W-1:0];
                dgv_pkg::CFG_PLANE_NZ:     nz_reg   <= cfg_data[dgv_pkg::NORM_W-1:0];
                dgv_pkg::CFG_PLANE_OFFSET: off_reg  <= cfg_data[dgv_pkg::OFF_W-1:0];
                dgv_pkg::CFG_MIN_HEIGHT:   minh_reg <= cfg_data[dgv_pkg::MINH_W-1:0];
                default: ;
            endcase
        end
    end

    dgv_mac u_mac (
        .clk    (clk),
        .op     (op),
        .offset (off_reg),
        .acc    (acc)
    );

    dgv_div3 u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc[dgv_pkg::DIV_SH+dgv_pkg::DIVX_W-1:dgv_pkg::DIV_SH]),
        .quotient (div_q),
        .done     (div_done)
    );

    // previous row of vertices, one entry per column
    dgv_ram #(
        .WIDTH ($bits(dgv_pkg::vertex_t)),
        .DEPTH (dgv_pkg::GRID_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (cur_reg),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        // triangle A is (UL, above, left), triangle B is (cur, left, above)
        v0  = tri_b_reg ? cur_reg   : ul_reg;
        v1  = tri_b_reg ? left_reg  : above_reg;
        v2  = tri_b_reg ? above_reg : left_reg;
        e0x = dgv_pkg::edge_of(v1.x, v0.x);
        e0y = dgv_pkg::edge_of(v1.y, v0.y);
        e0z = dgv_pkg::edge_of(v1.z, v0.z);
        e1x = dgv_pkg::edge_of(v2.x, v0.x);
        e1y = dgv_pkg::edge_of(v2.y, v0.y);
        e1z = dgv_pkg::edge_of(v2.z, v0.z);

        h_acc    = acc[dgv_pkg::H_W-1:0];
        min_term = {{(dgv_pkg::H_W-dgv_pkg::MINH_W-dgv_pkg::FRAC_SH){1'b0}},
                    minh_reg, {dgv_pkg::FRAC_SH{1'b0}}};
        d_acc    = acc[dgv_pkg::D_W-1:0];
        p_abs    = d_acc[dgv_pkg::D_W-1] ? dgv_pkg::D_W'(-d_acc) : dgv_pkg::D_W'(d_acc);
        sum_wide = {1'b0, sum_reg} + {1'b0, div_q[dgv_pkg::VOL_W-1:0]};

        last_step3 = (step_reg == 3'd2);
        last_step6 = (step_reg == 3'd5);

        // height walk: step picks the axis, second vertex in steps 3..5
        case (step_reg)
            3'd0, 3'd3: k = 2'd0;
            3'd1, 3'd4: k = 2'd1;
            default:    k = 2'd2;
        endcase
        case (state_reg)
            dgv_pkg::ST_HCUR: hv = cur_reg;
            dgv_pkg::ST_HV0:  hv = ul_reg;
            default:          hv = (step_reg < 3'd3) ? left_reg : above_reg;
        endcase

        // dot-product walk: high part then low part of each cross component
        case (step_reg)
            3'd0, 3'd1: begin csel = cx_reg; nsel = nx_reg; end
            3'd2, 3'd3: begin csel = cy_reg; nsel = ny_reg; end
            default:    begin csel = cz_reg; nsel = nz_reg; end
        endcase

        op         = '0;
        div_start  = 1'b0;
        ram_we     = 1'b0;

        state_next     = state_reg;
        step_next      = step_reg;
        tri_b_next     = tri_b_reg;
        do_a_next      = do_a_reg;
        do_b_next      = do_b_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        left_next      = left_reg;
        ul_next        = ul_reg;
        sum_next       = sum_reg;
        tally_next     = tally_reg;
        flag_next      = flag_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;
        cur_next       = cur_reg;
        fe_next        = fe_reg;
        above_next     = above_reg;
        hcur_next      = hcur_reg;
        hla_next       = hla_reg;
        hs_next        = hs_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        aq_next        = aq_reg;
        hq_next        = hq_reg;
        big_next       = big_reg;

        case (state_reg)
            dgv_pkg::ST_IDLE:
            begin
                if (accepted)
                begin
                    cur_next.x  = vtx.coord_x;
                    cur_next.y  = vtx.coord_y;
                    cur_next.z  = vtx.coord_z;
                    cur_next.ok = 1'b0;
                    fe_next     = vtx.frame_end;
                    state_next  = dgv_pkg::ST_HCUR;
                    step_next   = '0;
                end
            end

            dgv_pkg::ST_HCUR, dgv_pkg::ST_HV0, dgv_pkg::ST_HLA:
            begin
                if (state_reg == dgv_pkg::ST_HCUR && step_reg == '0)
                begin
                    above_next = ram_rdata;
                end
                op.clear   = (step_reg == '0);
                op.add_off = (step_reg == '0) || (step_reg == 3'd3);
                case (k)
                    2'd0:    begin op.a = dgv_pkg::ext_n(nx_reg); op.b = dgv_pkg::ext_c(hv.x); end
                    2'd1:    begin op.a = dgv_pkg::ext_n(ny_reg); op.b = dgv_pkg::ext_c(hv.y); end
                    default: begin op.a = dgv_pkg::ext_n(nz_reg); op.b = dgv_pkg::ext_c(hv.z); end
                endcase
                step_next = step_reg + 1'b1;
                if (state_reg == dgv_pkg::ST_HLA)
                begin
                    if (last_step6)
                    begin
                        state_next = dgv_pkg::ST_HLA_DONE;
                        step_next  = '0;
                    end
                end
                else if (last_step3)
                begin
                    state_next = (state_reg == dgv_pkg::ST_HCUR) ? dgv_pkg::ST_CHECK
                                                                 : dgv_pkg::ST_HSUM;
                    step_next  = '0;
                end
            end

            dgv_pkg::ST_CHECK:
            begin
                hcur_next   = h_acc;
                cur_next.ok = (cur_reg.x != '0) && (cur_reg.y != '0) && (cur_reg.z != '0)
                              && (h_acc > min_term);
                do_a_next   = (row_reg != '0) && (col_reg != '0) && above_reg.ok
                              && left_reg.ok && ul_reg.ok;
                do_b_next   = (row_reg != '0) && (col_reg != '0) && above_reg.ok
                              && left_reg.ok && cur_next.ok;
                state_next  = (do_a_next || do_b_next) ? dgv_pkg::ST_HLA : dgv_pkg::ST_FINISH;
            end

            dgv_pkg::ST_HLA_DONE:
            begin
                hla_next   = acc[dgv_pkg::HS_W-1:0];
                tri_b_next = !do_a_reg;
                state_next = do_a_reg ? dgv_pkg::ST_HV0 : dgv_pkg::ST_HSUM;
            end

            dgv_pkg::ST_HSUM:
            begin
                // centroid height sum: shared left+above part plus first corner
                hs_next    = hla_reg + (tri_b_reg ? dgv_pkg::HS_W'(hcur_reg)
                                                  : dgv_pkg::HS_W'(h_acc));
                state_next = dgv_pkg::ST_CROSS;
                step_next  = '0;
            end

            dgv_pkg::ST_CROSS:
            begin
                case (step_reg)
                    3'd0: begin op.clear = 1'b1; op.a = dgv_pkg::ext_e(e0y);  op.b = dgv_pkg::ext_e(e1z); end
                    3'd1: begin op.a = -dgv_pkg::ext_e(e0z); op.b = dgv_pkg::ext_e(e1y); end
                    3'd2: begin op.clear = 1'b1; op.a = dgv_pkg::ext_e(e0z);  op.b = dgv_pkg::ext_e(e1x); end
                    3'd3: begin op.a = -dgv_pkg::ext_e(e0x); op.b = dgv_pkg::ext_e(e1z); end
                    3'd4: begin op.clear = 1'b1; op.a = dgv_pkg::ext_e(e0x);  op.b = dgv_pkg::ext_e(e1y); end
                    default: begin op.a = -dgv_pkg::ext_e(e0y); op.b = dgv_pkg::ext_e(e1x); end
                endcase
                if (step_reg == 3'd2)
                begin
                    cx_next = acc[dgv_pkg::CROSS_W-1:0];
                end
                if (step_reg == 3'd4)
                begin
                    cy_next = acc[dgv_pkg::CROSS_W-1:0];
                end
                step_next = step_reg + 1'b1;
                if (last_step6)
                begin
                    state_next = dgv_pkg::ST_DOT;
                    step_next  = '0;
                end
            end

            dgv_pkg::ST_DOT:
            begin
                if (step_reg == '0)
                begin
                    cz_next = acc[dgv_pkg::CROSS_W-1:0];
                end
                op.clear = (step_reg == '0);
                op.a     = dgv_pkg::ext_n(nsel);
                op.shift = !step_reg[0];
                if (step_reg[0])
                begin
                    op.b = {1'b0, csel[dgv_pkg::SPLIT-1:0]};
                end
                else
                begin
                    op.b = {{(dgv_pkg::OPND_W-dgv_pkg::CROSS_W+dgv_pkg::SPLIT)
                             {csel[dgv_pkg::CROSS_W-1]}},
                            csel[dgv_pkg::CROSS_W-1:dgv_pkg::SPLIT]};
                end
                step_next = step_reg + 1'b1;
                if (last_step6)
                begin
                    state_next = dgv_pkg::ST_AREA;
                    step_next  = '0;
                end
            end

            dgv_pkg::ST_AREA:
            begin
                aq_next    = p_abs[dgv_pkg::AQ_SH+dgv_pkg::AQ_W-1:dgv_pkg::AQ_SH];
                hq_next    = (hs_reg > 0) ? hs_reg[dgv_pkg::FRAC_SH+dgv_pkg::HQ_W-1:dgv_pkg::FRAC_SH]
                                          : '0;
                state_next = dgv_pkg::ST_PROD;
                step_next  = '0;
            end

            dgv_pkg::ST_PROD:
            begin
                op.a = {1'b0, hq_reg};
                if (step_reg == '0)
                begin
                    op.clear = 1'b1;
                    op.b     = {1'b0, aq_reg[dgv_pkg::SPLIT-1:0]};
                    step_next = 3'd1;
                end
                else
                begin
                    op.shift = 1'b1;
                    op.b     = {{(dgv_pkg::OPND_W-dgv_pkg::AQ_W+dgv_pkg::SPLIT){1'b0}},
                                aq_reg[dgv_pkg::AQ_W-1:dgv_pkg::SPLIT]};
                    state_next = dgv_pkg::ST_DIV;
                    step_next  = '0;
                end
            end

            dgv_pkg::ST_DIV:
            begin
                if (step_reg == '0)
                begin
                    div_start = 1'b1;
                    big_next  = (acc[dgv_pkg::ACC_W-1:dgv_pkg::DIV_SH] >= dgv_pkg::DIV_LIMIT);
                    step_next = 3'd1;
                end
                else if (div_done)
                begin
                    state_next = dgv_pkg::ST_ACC;
                    step_next  = '0;
                end
            end

            dgv_pkg::ST_ACC:
            begin
                if (tally_reg != dgv_pkg::CNT_MAX)
                begin
                    tally_next = tally_reg + 1'b1;
                end
                if (big_reg || sum_wide[dgv_pkg::VOL_W])
                begin
                    sum_next  = dgv_pkg::VOL_MAX;
                    flag_next = 1'b1;
                end
                else
                begin
                    sum_next = sum_wide[dgv_pkg::VOL_W-1:0];
                end
                if (!tri_b_reg && do_b_reg)
                begin
                    tri_b_next = 1'b1;
                    state_next = dgv_pkg::ST_HSUM;
                end
                else
                begin
                    state_next = dgv_pkg::ST_FINISH;
                end
            end

            dgv_pkg::ST_FINISH:
            begin
                ram_we = 1'b1;
                if (!hold_out)
                begin
                    ul_next   = above_reg;
                    left_next = cur_reg;
                    if (col_reg == dgv_pkg::COL_W'(dgv_pkg::GRID_WIDTH - 1))
                    begin
                        col_next = '0;
                        if (row_reg != dgv_pkg::ROW_W'(dgv_pkg::GRID_HEIGHT - 1))
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                    if (fe_reg)
                    begin
                        res_valid_next          = 1'b1;
                        res_next.volume_mm3     = sum_reg;
                        res_next.triangle_count = tally_reg;
                        res_next.overflow       = flag_reg;
                        col_next   = '0;
                        row_next   = '0;
                        left_next  = '0;
                        ul_next    = '0;
                        sum_next   = '0;
                        tally_next = '0;
                        flag_next  = 1'b0;
                    end
                    state_next = dgv_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = dgv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dgv_pkg::ST_IDLE;
            step_reg      <= '0;
            tri_b_reg     <= 1'b0;
            do_a_reg      <= 1'b0;
            do_b_reg      <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            ul_reg        <= '0;
            sum_reg       <= '0;
            tally_reg     <= '0;
            flag_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            tri_b_reg     <= tri_b_next;
            do_a_reg      <= do_a_next;
            do_b_reg      <= do_b_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            left_reg      <= left_next;
            ul_reg        <= ul_next;
            sum_reg       <= sum_next;
            tally_reg     <= tally_next;
            flag_reg      <= flag_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res_next;
        cur_reg   <= cur_next;
        fe_reg    <= fe_next;
        above_reg <= above_next;
        hcur_reg  <= hcur_next;
        hla_reg   <= hla_next;
        hs_reg    <= hs_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cz_reg    <= cz_next;
        aq_reg    <= aq_next;
        hq_reg    <= hq_next;
        big_reg   <= big_next;
    end

    // an accepted item always starts with the height of the new vertex
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accepted |=> (state_reg == dgv_pkg::ST_HCUR) && (step_reg == '0))
        else $error("accepted item did not start height pass");

    // a result appears only from the close of a frame
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == dgv_pkg::ST_FINISH && fe_reg))
        else $error("result without frame end");

    // saturation flag implies the sum sits at its ceiling
    a_sat_sum: assert property (@(posedge clk) disable iff (!rst_n)
        flag_reg |-> (sum_reg == dgv_pkg::VOL_MAX))
        else $error("saturated flag with sum below ceiling");

    // divider completes only while the sequencer waits for it
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == dgv_pkg::ST_DIV) && (step_reg != '0))
        else $error("divider finished outside its wait state");

endmodule
